FILE: rtl/lwrp_pkg.sv
// shared types and constants of the least-width row packer
// no dependencies; lwrp_ctrl, lwrp_dp and the top level refer to it by scoped names
`default_nettype none

package lwrp_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_PIXELS = 1'd1;

	// field widths
	localparam int ROWS_CFG_W = 5;
	localparam int PAD_W = 8;
	localparam int DIM_W = 12;
	localparam int SUM_W = 20;
	localparam int INDEX_W = 8;
	localparam int ROW_OUT_W = 4;
	localparam logic [SUM_W-1:0] SUM_MAX = 20'hFFFFF;

	// input item
	typedef struct packed {
		logic start_set;
		logic supported;
		logic [DIM_W-1:0] item_width;
		logic [DIM_W-1:0] item_height;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [INDEX_W-1:0] item_index;
		logic placed;
		logic [ROW_OUT_W-1:0] row_chosen;
		logic [SUM_W-1:0] total_width;
		logic [SUM_W-1:0] total_height;
	} out_item_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan_rd;
		logic update;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_addr;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/lwrp_stream_if.sv
// valid/ready stream channel carrying one payload of a given type
// depends on nothing; payload types come from lwrp_pkg at the instance
`default_nettype none

interface lwrp_stream_if #(
	parameter type data_t = logic
) ();
	logic valid;
	logic ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/lwrp_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module lwrp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/lwrp_ctrl.sv
// controller: sequences accept, row scan, row update and result transfer
// depends on lwrp_pkg
`default_nettype none

module lwrp_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	input wire logic item_supp,
	output logic item_ready,
	output lwrp_pkg::cmd_t cmd,
	input wire lwrp_pkg::status_t stat
);

	lwrp_pkg::state_t state_q;
	lwrp_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lwrp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		item_ready = 1'b0;
		case (state_q)
			lwrp_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d = item_supp ? lwrp_pkg::ST_SCAN : lwrp_pkg::ST_EMIT;
				end
			end
			lwrp_pkg::ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (stat.last_addr) begin
					state_d = lwrp_pkg::ST_DRAIN;
				end
			end
			lwrp_pkg::ST_DRAIN: begin
				state_d = lwrp_pkg::ST_UPDATE;
			end
			lwrp_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d = lwrp_pkg::ST_EMIT;
			end
			lwrp_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = lwrp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lwrp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/lwrp_dp.sv
// datapath: row store, least-width scan, sums, counter and output register
// depends on lwrp_pkg and lwrp_ram
`default_nettype none

module lwrp_dp #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_ITEMS = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire lwrp_pkg::cmd_t cmd,
	output lwrp_pkg::status_t stat,
	input wire logic [lwrp_pkg::ROWS_CFG_W-1:0] rows_cfg,
	input wire logic [lwrp_pkg::PAD_W-1:0] pad_cfg,
	input wire lwrp_pkg::in_item_t item,
	input wire logic res_ready,
	output logic res_valid,
	output lwrp_pkg::out_item_t res_data
);

	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int RN_W = $clog2(MAX_ROWS + 1);
	localparam int CNT_W = $clog2(MAX_ITEMS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_ITEMS - 1);
	localparam int SW = lwrp_pkg::SUM_W;
	localparam int DW = lwrp_pkg::DIM_W;
	localparam int ENTRY_W = SW + DW;

	// set state
	logic [MAX_ROWS-1:0] valid_q;
	logic [lwrp_pkg::PAD_W-1:0] start_pad_q;
	logic [SW-1:0] ow_q;
	logic [SW-1:0] oh_q;
	logic [CNT_W-1:0] cnt_q;
	logic res_valid_q;
	logic rd_v_s1;

	// item and scan payload
	logic [DW-1:0] w_q;
	logic [DW-1:0] h_q;
	logic supp_q;
	logic [CNT_W-1:0] idx_q;
	logic [RN_W-1:0] n_q;
	logic [ROW_W-1:0] addr_q;
	logic [ROW_W-1:0] rd_idx_s1;
	logic [ROW_W-1:0] best_q;
	logic [SW-1:0] best_w_q;
	logic [DW-1:0] best_h_q;
	lwrp_pkg::out_item_t res_q;

	// ram signals
	logic [ENTRY_W-1:0] rd_data;
	logic [ENTRY_W-1:0] wr_data;

	// effective row count and start values
	logic [6:0] rows7;
	logic [6:0] n7;
	logic [14:0] start_h;
	logic [CNT_W-1:0] cnt_base;
	logic [SW-1:0] eff_w;
	logic [DW-1:0] eff_h;

	// update arithmetic
	logic [SW+1:0] wsum;
	logic [SW-1:0] new_w;
	logic [DW-1:0] new_h;
	logic [SW-1:0] h_base;
	logic [SW:0] h_sum;
	logic [SW-1:0] new_oh;

	// output fields
	logic [CNT_W+7:0] idx_ext;
	logic [ROW_W+3:0] best_ext;

	assign rows7 = {2'b0, rows_cfg};
	assign n7 = (rows7 == 7'd0) ? 7'd1
		: ((rows7 > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows7);
	assign start_h = {7'b0, pad_cfg} * {8'b0, n7 + 7'd1};
	assign cnt_base = item.start_set ? '0 : cnt_q;

	// rows not written since the last start read as their start values
	assign eff_w = valid_q[rd_idx_s1] ? rd_data[SW-1:0] : {12'b0, start_pad_q};
	assign eff_h = valid_q[rd_idx_s1] ? rd_data[ENTRY_W-1:SW] : '0;

	// saturating row growth and height bookkeeping
	assign wsum = {2'b0, best_w_q} + {10'b0, w_q} + {14'b0, pad_cfg};
	assign new_w = (wsum > {2'b0, lwrp_pkg::SUM_MAX}) ? lwrp_pkg::SUM_MAX : wsum[SW-1:0];
	assign new_h = (best_h_q < h_q) ? h_q : best_h_q;
	assign h_base = (oh_q >= {8'b0, best_h_q}) ? (oh_q - {8'b0, best_h_q}) : '0;
	assign h_sum = {1'b0, h_base} + {9'b0, h_q};
	assign new_oh = (h_sum > {1'b0, lwrp_pkg::SUM_MAX}) ? lwrp_pkg::SUM_MAX : h_sum[SW-1:0];
	assign wr_data = {new_h, new_w};

	assign stat = '{
		last_addr: (8'(addr_q) + 8'd1) == 8'(n_q),
		out_free: !res_valid_q || res_ready
	};

	assign idx_ext = {8'b0, idx_q};
	assign best_ext = {4'b0, best_q};

	// row store
	lwrp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_ROWS)
	) u_row_ram (
		.clk(clk),
		.we(cmd.update),
		.waddr(best_q),
		.wdata(wr_data),
		.raddr(addr_q),
		.rdata(rd_data)
	);

	// set state and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			start_pad_q <= '0;
			ow_q <= '0;
			oh_q <= '0;
			cnt_q <= '0;
			res_valid_q <= 1'b0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				if (cnt_base != CNT_LAST) begin
					cnt_q <= cnt_base + 1'b1;
				end else begin
					cnt_q <= cnt_base;
				end
				if (item.start_set) begin
					valid_q <= '0;
					start_pad_q <= pad_cfg;
					ow_q <= {12'b0, pad_cfg};
					oh_q <= {5'b0, start_h};
				end
			end
			if (cmd.update) begin
				valid_q[best_q] <= 1'b1;
				if (ow_q < new_w) begin
					ow_q <= new_w;
				end
				if (best_h_q < h_q) begin
					oh_q <= new_oh;
				end
			end
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// item capture, scan compare and result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q <= item.item_width;
			h_q <= item.item_height;
			supp_q <= item.supported;
			idx_q <= cnt_base;
			n_q <= n7[RN_W-1:0];
			addr_q <= '0;
		end
		if (cmd.scan_rd) begin
			addr_q <= addr_q + 1'b1;
			rd_idx_s1 <= addr_q;
		end
		// strictly smaller width wins, so ties keep the lower row
		if (rd_v_s1) begin
			if (rd_idx_s1 == '0 || best_w_q > eff_w) begin
				best_q <= rd_idx_s1;
				best_w_q <= eff_w;
				best_h_q <= eff_h;
			end
		end
		if (cmd.out_load) begin
			res_q.item_index <= idx_ext[7:0];
			res_q.placed <= supp_q;
			res_q.row_chosen <= supp_q ? best_ext[3:0] : '0;
			res_q.total_width <= ow_q;
			res_q.total_height <= oh_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data = res_q;

endmodule

`default_nettype wire

FILE: rtl/least_width_row_packer.sv
// least-width row packer: top level with configuration registers
// depends on lwrp_pkg, lwrp_stream_if, lwrp_ctrl and lwrp_dp
//
// Usage:
//   items carries one rectangle per transfer (start_set, supported, size);
//   results returns exactly one result per item, in order.
//   Configuration (rows_in_use index 0, pad_pixels index 1) is written via
//   cfg_we/cfg_index/cfg_data while no item is in flight.
// Sequence:
//   One item at a time. A supported item passes from accept through a ram read
//   per row, a drain state for the last read data and a row update to the
//   result load; an unsupported item goes from accept straight to the result
//   load. The next item is accepted only once the result has been loaded.
// Reset:
//   arst_n clears all row state, sums and counter; rows_in_use becomes 1 and
//   pad_pixels 0. Rows read as their start value until first written, so
//   starting a set needs no clearing pass over the row store.
// Stall:
//   The result register holds a finished result while results.ready is low;
//   the next item is still accepted and worked on, and waits only to load it.
`default_nettype none

module least_width_row_packer #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_ITEMS = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [lwrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [lwrp_pkg::CFG_DATA_W-1:0] cfg_data,
	lwrp_stream_if.sink items,
	lwrp_stream_if.source results
);

	logic [lwrp_pkg::ROWS_CFG_W-1:0] rows_q;
	logic [lwrp_pkg::PAD_W-1:0] pad_q;
	lwrp_pkg::cmd_t cmd;
	lwrp_pkg::status_t stat;
	lwrp_pkg::in_item_t item;
	lwrp_pkg::out_item_t res;
	logic res_valid;
	logic item_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= lwrp_pkg::ROWS_CFG_W'(1);
			pad_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lwrp_pkg::CFG_ROWS_IN_USE: rows_q <= cfg_data[lwrp_pkg::ROWS_CFG_W-1:0];
				lwrp_pkg::CFG_PAD_PIXELS: pad_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign item = items.data;
	assign items.ready = item_ready;
	assign results.valid = res_valid;
	assign results.data = res;

	lwrp_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(items.valid),
		.item_supp(item.supported),
		.item_ready(item_ready),
		.cmd(cmd),
		.stat(stat)
	);

	lwrp_dp #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_ITEMS(MAX_ITEMS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.rows_cfg(rows_q),
		.pad_cfg(pad_q),
		.item(item),
		.res_ready(results.ready),
		.res_valid(res_valid),
		.res_data(res)
	);

	// a result is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result register overwritten");

	// only one item in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready) |=> !items.ready)
		else $error("item accepted while another is in flight");

	// scan stops after the last row in use
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_rd && stat.last_addr) |=> !cmd.scan_rd)
		else $error("row scan ran past the last row");

	// a row is only updated for an item that went through a scan
	a_update_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> $past(!cmd.scan_rd && !cmd.load))
		else $error("row update without a finished scan");

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps
// testbench for the least-width row packer: directed and random rectangle streams
// depends on lwrp_pkg, lwrp_stream_if and least_width_row_packer from the rtl folder

module tb;

	localparam int ROW_SLOTS = 16;
	localparam int SET_SLOTS = 256;
	localparam int ITEM_TARGET = 1700;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 40;

	// predicts every placement and checks results in arrival order
	class placement_scoreboard;
		logic [lwrp_pkg::ROWS_CFG_W-1:0] rows_cfg;
		logic [lwrp_pkg::PAD_W-1:0] pad;
		logic [lwrp_pkg::SUM_W-1:0] row_w [ROW_SLOTS];
		logic [lwrp_pkg::DIM_W-1:0] row_h [ROW_SLOTS];
		logic [lwrp_pkg::SUM_W-1:0] width_so_far;
		logic [lwrp_pkg::SUM_W-1:0] height_so_far;
		int unsigned set_pos;
		lwrp_pkg::out_item_t placements_due [$];
		int mismatches;
		int checked;
		int placed_cnt;
		int sets_started;
		int saturated;

		function new();
			rows_cfg = lwrp_pkg::ROWS_CFG_W'(1);
			pad = '0;
			for (int i = 0; i < ROW_SLOTS; i++) begin
				row_w[i] = '0;
				row_h[i] = '0;
			end
			width_so_far = '0;
			height_so_far = '0;
			set_pos = 0;
			mismatches = 0;
			checked = 0;
			placed_cnt = 0;
			sets_started = 0;
			saturated = 0;
		endfunction

		// zero counts as one row, anything above the row slots as all of them
		function int unsigned live_rows();
			if (rows_cfg == 0)
				return 1;
			if (rows_cfg > ROW_SLOTS)
				return ROW_SLOTS;
			return 32'(rows_cfg);
		endfunction

		function logic [lwrp_pkg::SUM_W-1:0] clip(longint unsigned v);
			return (v > lwrp_pkg::SUM_MAX) ? lwrp_pkg::SUM_MAX : v[lwrp_pkg::SUM_W-1:0];
		endfunction

		function void set_reg(logic [lwrp_pkg::CFG_IDX_W-1:0] idx,
				logic [lwrp_pkg::CFG_DATA_W-1:0] value);
			if (idx == lwrp_pkg::CFG_ROWS_IN_USE)
				rows_cfg = value[lwrp_pkg::ROWS_CFG_W-1:0];
			else if (idx == lwrp_pkg::CFG_PAD_PIXELS)
				pad = value[lwrp_pkg::PAD_W-1:0];
		endfunction

		function void accept_rect(lwrp_pkg::in_item_t r);
			int unsigned best;
			longint unsigned grown;
			longint unsigned base;
			lwrp_pkg::out_item_t due;
			// a new set restarts every row from the padding
			if (r.start_set) begin
				for (int i = 0; i < ROW_SLOTS; i++) begin
					row_w[i] = lwrp_pkg::SUM_W'(pad);
					row_h[i] = '0;
				end
				width_so_far = lwrp_pkg::SUM_W'(pad);
				height_so_far = clip(64'(pad) * 64'(live_rows() + 1));
				set_pos = 0;
				sets_started++;
			end
			due.item_index = set_pos[lwrp_pkg::INDEX_W-1:0];
			if (set_pos < SET_SLOTS - 1)
				set_pos++;
			best = 0;
			// least loaded row wins, lowest index on a tie
			if (r.supported) begin
				for (int j = 1; j < live_rows(); j++)
					if (row_w[best] > row_w[j])
						best = j;
				grown = 64'(row_w[best]) + 64'(r.item_width) + 64'(pad);
				if (grown > lwrp_pkg::SUM_MAX)
					saturated++;
				row_w[best] = clip(grown);
				if (width_so_far < row_w[best])
					width_so_far = row_w[best];
				if (row_h[best] < r.item_height) begin
					base = (height_so_far >= row_h[best]) ?
						64'(height_so_far - row_h[best]) : 64'd0;
					height_so_far = clip(base + 64'(r.item_height));
					row_h[best] = r.item_height;
				end
				placed_cnt++;
			end
			due.placed = r.supported;
			due.row_chosen = r.supported ? best[lwrp_pkg::ROW_OUT_W-1:0] : '0;
			due.total_width = width_so_far;
			due.total_height = height_so_far;
			placements_due.insert(placements_due.size(), due);
		endfunction

		function void check_result(lwrp_pkg::out_item_t got);
			lwrp_pkg::out_item_t due;
			if (placements_due.size() == 0) begin
				$error("result with no rectangle pending, item_index %0d", got.item_index);
				mismatches++;
				return;
			end
			due = placements_due.pop_front();
			checked++;
			if (got.item_index !== due.item_index) begin
				$error("item_index: expected %0d, actual %0d", due.item_index, got.item_index);
				mismatches++;
			end
			if (got.placed !== due.placed) begin
				$error("placed: expected %0d, actual %0d", due.placed, got.placed);
				mismatches++;
			end
			if (got.row_chosen !== due.row_chosen) begin
				$error("row_chosen: expected %0d, actual %0d", due.row_chosen, got.row_chosen);
				mismatches++;
			end
			if (got.total_width !== due.total_width) begin
				$error("total_width: expected %0d, actual %0d",
					due.total_width, got.total_width);
				mismatches++;
			end
			if (got.total_height !== due.total_height) begin
				$error("total_height: expected %0d, actual %0d",
					due.total_height, got.total_height);
				mismatches++;
			end
		endfunction

		function int pending();
			return placements_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [lwrp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [lwrp_pkg::CFG_DATA_W-1:0] cfg_data;
	bit no_gaps;
	int sent = 0;
	int stall_cycles = 0;

	lwrp_stream_if #(.data_t(lwrp_pkg::in_item_t)) rect_ch ();
	lwrp_stream_if #(.data_t(lwrp_pkg::out_item_t)) place_ch ();

	placement_scoreboard sb = new();

	least_width_row_packer #(
		.MAX_ROWS(ROW_SLOTS),
		.MAX_ITEMS(SET_SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.items(rect_ch),
		.results(place_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side back-pressure
	initial begin
		place_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			place_ch.ready <= no_gaps || ($urandom_range(99) >= 24);
		end
	end

	// result check and watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (place_ch.valid && place_ch.ready)
				sb.check_result(place_ch.data);
			if ((place_ch.valid && place_ch.ready) || (rect_ch.valid && rect_ch.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("tb NOT OK");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	function automatic lwrp_pkg::in_item_t rect(bit start, bit supp, int unsigned w,
			int unsigned h);
		lwrp_pkg::in_item_t r;
		r.start_set = start;
		r.supported = supp;
		r.item_width = w[lwrp_pkg::DIM_W-1:0];
		r.item_height = h[lwrp_pkg::DIM_W-1:0];
		return r;
	endfunction

	function automatic logic [lwrp_pkg::DIM_W-1:0] random_dim();
		case ($urandom_range(3))
			0: return lwrp_pkg::DIM_W'($urandom_range(4095));
			1: return lwrp_pkg::DIM_W'($urandom_range(31));
			2: return lwrp_pkg::DIM_W'(4095 - $urandom_range(31));
			default: return lwrp_pkg::DIM_W'($urandom_range(511));
		endcase
	endfunction

	// mostly placed rectangles, with a rare stray start inside a set
	function automatic lwrp_pkg::in_item_t random_rect(bit first);
		lwrp_pkg::in_item_t r;
		r.start_set = first || ($urandom_range(99) < 2);
		r.supported = $urandom_range(99) < 85;
		r.item_width = random_dim();
		r.item_height = random_dim();
		return r;
	endfunction

	// row count with the unused upper data bits scrambled
	function automatic logic [lwrp_pkg::CFG_DATA_W-1:0] pick_rows();
		logic [lwrp_pkg::ROWS_CFG_W-1:0] rows;
		logic [lwrp_pkg::CFG_DATA_W-lwrp_pkg::ROWS_CFG_W-1:0] junk;
		case ($urandom_range(7))
			0: rows = lwrp_pkg::ROWS_CFG_W'(1);
			1: rows = lwrp_pkg::ROWS_CFG_W'(16);
			2: rows = '0;
			3: rows = lwrp_pkg::ROWS_CFG_W'($urandom_range(31, 17));
			default: rows = lwrp_pkg::ROWS_CFG_W'($urandom_range(15, 2));
		endcase
		junk = 3'($urandom_range(7));
		return {junk, rows};
	endfunction

	function automatic logic [lwrp_pkg::CFG_DATA_W-1:0] pick_pad();
		case ($urandom_range(3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_rect(input lwrp_pkg::in_item_t r);
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 24) begin
			rect_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rect_ch.valid <= 1'b1;
		rect_ch.data <= r;
		do @(posedge clk); while (!rect_ch.ready);
		sb.accept_rect(r);
		sent++;
	endtask

	task automatic send_set(input int unsigned len, input bit fresh);
		for (int k = 0; k < len; k++)
			send_rect(random_rect(fresh && k == 0));
	endtask

	// stop sending and wait for every outstanding result
	task automatic settle();
		@(negedge clk);
		rect_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [lwrp_pkg::CFG_IDX_W-1:0] idx,
			input logic [lwrp_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	initial begin
		bit sat_done;
		sat_done = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		rect_ch.valid = 1'b0;
		rect_ch.data = '0;
		no_gaps = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// rectangles before any set start work on the reset state
		send_rect(rect(0, 1, 4095, 4095));
		send_rect(rect(0, 0, 4095, 4095));
		send_rect(rect(0, 1, 0, 0));
		settle();

		// four rows, widest padding: ties, zero and full sizes, a skipped one
		write_reg(lwrp_pkg::CFG_ROWS_IN_USE, 8'd4);
		write_reg(lwrp_pkg::CFG_PAD_PIXELS, 8'd255);
		send_rect(rect(1, 1, 0, 0));
		send_rect(rect(0, 1, 4095, 4095));
		send_rect(rect(0, 1, 0, 1));
		send_rect(rect(0, 0, 4095, 4095));
		send_rect(rect(0, 1, 0, 4095));
		send_rect(rect(0, 1, 1, 2));
		settle();

		// zero rows acts as one, changed inside the running set
		write_reg(lwrp_pkg::CFG_ROWS_IN_USE, 8'd0);
		write_reg(lwrp_pkg::CFG_PAD_PIXELS, 8'd0);
		send_rect(rect(0, 1, 7, 9));
		send_rect(rect(0, 1, 4095, 0));
		settle();

		// a count above the row slots acts as all of them
		write_reg(lwrp_pkg::CFG_ROWS_IN_USE, 8'hF1);
		write_reg(lwrp_pkg::CFG_PAD_PIXELS, 8'd1);
		send_rect(rect(1, 1, 100, 50));
		send_rect(rect(0, 0, 0, 0));
		send_rect(rect(0, 1, 4095, 4095));
		settle();

		write_reg(lwrp_pkg::CFG_ROWS_IN_USE, 8'd16);
		write_reg(lwrp_pkg::CFG_PAD_PIXELS, 8'd128);
		send_rect(rect(1, 0, 4095, 4095));
		send_rect(rect(1, 1, 4095, 4095));
		send_rect(rect(0, 1, 0, 0));

		// random phases; those begun with 600 to 899 items sent run without any idling
		while (sent < ITEM_TARGET) begin
			settle();
			no_gaps = (sent >= 600 && sent < 900);
			if (!sat_done && sent >= 1000) begin
				// one long row: widths hit the ceiling and the index stops counting
				write_reg(lwrp_pkg::CFG_ROWS_IN_USE, 8'd1);
				write_reg(lwrp_pkg::CFG_PAD_PIXELS, 8'd255);
				send_rect(rect(1, 1, 4095, 4095));
				repeat (299)
					send_rect(rect(0, 1, 4095 - $urandom_range(7), $urandom_range(4095)));
				sat_done = 1'b1;
			end else begin
				if ($urandom_range(3) != 0)
					write_reg(lwrp_pkg::CFG_ROWS_IN_USE, pick_rows());
				if ($urandom_range(3) != 0)
					write_reg(lwrp_pkg::CFG_PAD_PIXELS, pick_pad());
				repeat ($urandom_range(4, 1))
					send_set($urandom_range(40, 1), $urandom_range(5) != 0);
			end
		end

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("placed %0d of %0d rectangles over %0d sets, %0d row growths clipped",
			sb.placed_cnt, sent, sb.sets_started, sb.saturated);
		$display("%0d results compared field by field", sb.checked);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
